// ===== hw/rtl/sorted_list_union_merge_defines.svh =====
// Assertion macros used by the checker of the union merge block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef SORTED_LIST_UNION_MERGE_DEFINES_SVH
`define SORTED_LIST_UNION_MERGE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SLUM_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slum_checker: same-cycle property failed");

// Next-cycle implication, ignored while reset is asserted.
`define SLUM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slum_checker: next-cycle property failed");

// State seen on the cycle after a reset edge.
`define SLUM_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("slum_checker: reset property failed");

`endif

// ===== hw/rtl/slum_pkg.sv =====
`timescale 1ns / 1ps

package slum_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int FUNC_W         = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN           = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] union_value;
        logic                      last;
        logic                      empty_res;
        logic                      overflow;
    } t_out;

    typedef struct packed {
        logic wr_first;
        logic wr_second;
    } t_wr_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

// ===== hw/rtl/slum_ram.sv =====
`timescale 1ns / 1ps

module slum_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/slum_merge.sv =====
`timescale 1ns / 1ps

module slum_merge #(
    parameter int  LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF,
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  slum_pkg::t_in                 i_data,
    output logic                          o_stall,
    output logic                          o_valid,
    output slum_pkg::t_out                o_data,
    input  logic                          i_stall,
    output slum_pkg::t_wr_sel             o_wr_sel,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [slum_pkg::VALUE_W-1:0]  o_wr_data,
    output logic [AW-1:0]                 o_rd_addr_a,
    output logic [AW-1:0]                 o_rd_addr_b,
    input  logic [slum_pkg::VALUE_W-1:0]  i_rd_data_a,
    input  logic [slum_pkg::VALUE_W-1:0]  i_rd_data_b
);

    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    slum_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ptr_a, n_ptr_a, r_ptr_b, n_ptr_b;
    logic          r_drop, n_drop;
    logic          r_pend_valid, n_pend_valid;
    logic          r_pend_empty, n_pend_empty;
    logic [slum_pkg::VALUE_W-1:0] r_pend_value, n_pend_value;
    logic           r_out_valid, n_out_valid;
    slum_pkg::t_out r_out, n_out;

    logic w_accept, w_slot, w_take_a, w_done, w_need_emit, w_step, w_both_zero;
    logic [slum_pkg::VALUE_W-1:0] w_pick;

    assign o_stall  = (r_state != slum_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    // The output register can take a new result if it is empty or drains now.
    assign w_slot   = !r_out_valid || !i_stall;

    assign w_both_zero = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign w_done      = (r_ptr_a >= r_cnt_a) && (r_ptr_b >= r_cnt_b);
    assign w_take_a    = (r_ptr_a < r_cnt_a) &&
                         ((r_ptr_b >= r_cnt_b) ||
                          ($signed(i_rd_data_a) <= $signed(i_rd_data_b)));
    assign w_pick      = w_take_a ? i_rd_data_a : i_rd_data_b;
    // A held value is only sent once a different value shows up, so the
    // final one can still be marked last when the walk ends.
    assign w_need_emit = r_pend_valid && (w_pick != r_pend_value);
    assign w_step      = !w_done && (!w_need_emit || w_slot);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slum_pkg::ST_IDLE: begin
                if (w_accept && (i_data.func == slum_pkg::FUNC_RUN)) begin
                    n_state = w_both_zero ? slum_pkg::ST_FLUSH : slum_pkg::ST_WALK;
                end
            end
            slum_pkg::ST_WALK: begin
                if (w_done) begin
                    n_state = slum_pkg::ST_FLUSH;
                end
            end
            slum_pkg::ST_FLUSH: begin
                if (w_slot) begin
                    n_state = slum_pkg::ST_IDLE;
                end
            end
            default: n_state = slum_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ptr_a      = r_ptr_a;
        n_ptr_b      = r_ptr_b;
        n_drop       = r_drop;
        n_pend_valid = r_pend_valid;
        n_pend_empty = r_pend_empty;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && i_stall;
        n_out        = r_out;
        o_wr_sel     = '0;
        unique case (r_state)
            slum_pkg::ST_IDLE: begin
                n_ptr_a = '0;
                n_ptr_b = '0;
                if (w_accept) begin
                    unique case (i_data.func)
                        slum_pkg::FUNC_APPEND_FIRST: begin
                            if (r_cnt_a < DEPTH_C) begin
                                o_wr_sel.wr_first = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        slum_pkg::FUNC_APPEND_SECOND: begin
                            if (r_cnt_b < DEPTH_C) begin
                                o_wr_sel.wr_second = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        slum_pkg::FUNC_RUN: begin
                            n_pend_valid = w_both_zero;
                            n_pend_empty = w_both_zero;
                            n_pend_value = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slum_pkg::ST_WALK: begin
                if (w_step) begin
                    if (w_take_a) begin
                        n_ptr_a = r_ptr_a + CW'(1);
                    end else begin
                        n_ptr_b = r_ptr_b + CW'(1);
                    end
                    if (!r_pend_valid || w_need_emit) begin
                        n_pend_valid = 1'b1;
                        n_pend_value = w_pick;
                    end
                    if (w_need_emit) begin
                        n_out_valid       = 1'b1;
                        n_out.union_value = r_pend_value;
                        n_out.last        = 1'b0;
                        n_out.empty_res   = 1'b0;
                        n_out.overflow    = r_drop;
                    end
                end
            end
            slum_pkg::ST_FLUSH: begin
                if (w_slot) begin
                    n_out_valid       = 1'b1;
                    n_out.union_value = r_pend_value;
                    n_out.last        = 1'b1;
                    n_out.empty_res   = r_pend_empty;
                    n_out.overflow    = r_drop;
                    n_pend_valid      = 1'b0;
                    n_cnt_a           = '0;
                    n_cnt_b           = '0;
                    n_drop            = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slum_pkg::ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ptr_a      <= '0;
            r_ptr_b      <= '0;
            r_drop       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ptr_a      <= n_ptr_a;
            r_ptr_b      <= n_ptr_b;
            r_drop       <= n_drop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_empty <= n_pend_empty;
        r_pend_value <= n_pend_value;
        r_out        <= n_out;
    end

    // Reading at the next pointer keeps the RAM data aligned with the pointer
    // registers, so one element is consumed every cycle of the walk unless a stalled output holds it.
    assign o_rd_addr_a = n_ptr_a[AW-1:0];
    assign o_rd_addr_b = n_ptr_b[AW-1:0];
    assign o_wr_addr   = o_wr_sel.wr_first ? r_cnt_a[AW-1:0] : r_cnt_b[AW-1:0];
    assign o_wr_data   = i_data.value;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/sorted_list_union_merge.sv =====
`timescale 1ns / 1ps

// Sorted list union merge. Append requests (func 0 or 1) write the value into
// the first or second list RAM; a list holds up to LIST_DEPTH values, and
// appends beyond that are dropped and flagged in the overflow bit of the next
// run. A run request (func 2) walks both lists as a two-pointer merge at one
// element per cycle while the output does not stall, limited by the single
// read port of each list RAM, and returns the ascending union without repeats,
// the final result marked last. The input stays stalled until the run is
// done; a run on two empty lists returns a single zero result with empty_res
// set. The lists and the overflow flag are cleared when the run finishes.
// Func code 3 is accepted and ignored.
module sorted_list_union_merge #(
    parameter int LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  slum_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output slum_pkg::t_out o_data,
    input  logic           i_stall
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    slum_pkg::t_wr_sel            w_wr_sel;
    logic [AW-1:0]                w_wr_addr, w_rd_addr_a, w_rd_addr_b;
    logic [slum_pkg::VALUE_W-1:0] w_wr_data, w_rd_data_a, w_rd_data_b;

    slum_merge #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .o_wr_sel    (w_wr_sel),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b)
    );

    slum_ram #(
        .WIDTH (slum_pkg::VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_first_list (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_sel.wr_first),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr_a),
        .o_rd_data (w_rd_data_a)
    );

    slum_ram #(
        .WIDTH (slum_pkg::VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_second_list (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_sel.wr_second),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr_b),
        .o_rd_data (w_rd_data_b)
    );

endmodule

// ===== hw/rtl/slum_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_list_union_merge_defines.svh"

module slum_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input slum_pkg::t_in  i_data,
    input logic           o_stall,
    input logic           o_valid,
    input slum_pkg::t_out o_data,
    input logic           i_stall
);

    // Reset leaves no result pending and the block ready for requests.
    `SLUM_ASSERT_RESET(a_reset_idle, !o_valid && !o_stall)

    // An accepted run request always stalls the input on the next cycle.
    `SLUM_ASSERT_NEXT(a_run_stalls, i_valid && !o_stall && (i_data.func == slum_pkg::FUNC_RUN), o_stall)

    // A result that is not the final one means the run is still going.
    `SLUM_ASSERT_HOLD(a_mid_run, o_valid && !o_data.last, o_stall)

    // The empty marker only comes as the sole, final, zero result.
    `SLUM_ASSERT_HOLD(a_empty_form, o_valid && o_data.empty_res, o_data.last && (o_data.union_value == 0))

    // A stalled result holds its value.
    `SLUM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

bind sorted_list_union_merge slum_checker u_checker (.*);

// ===== dv/sorted_list_union_merge_checker.sv =====
`timescale 1ns / 1ps

module sorted_list_union_merge_checker #(
    parameter int LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  slum_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  slum_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic signed [slum_pkg::VALUE_W-1:0] first_vals [LIST_DEPTH];
    logic signed [slum_pkg::VALUE_W-1:0] second_vals [LIST_DEPTH];
    int   first_len;
    int   second_len;
    logic dropped;
    slum_pkg::t_out union_queue [$];
    int   fail_total;

    task automatic queue_result(input slum_pkg::t_out res);
        union_queue.insert(union_queue.size(), res);
    endtask

    // Apply one accepted request to the list copies and queue the union it yields.
    task automatic absorb_request(input slum_pkg::t_in req);
        int   ia;
        int   ib;
        bit   have;
        logic signed [slum_pkg::VALUE_W-1:0] pick;
        slum_pkg::t_out held;
        ia   = 0;
        ib   = 0;
        have = 1'b0;
        held = '0;
        case (req.func)
            slum_pkg::FUNC_APPEND_FIRST: begin
                if (first_len < LIST_DEPTH) begin
                    first_vals[first_len] = req.value;
                    first_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            slum_pkg::FUNC_APPEND_SECOND: begin
                if (second_len < LIST_DEPTH) begin
                    second_vals[second_len] = req.value;
                    second_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            slum_pkg::FUNC_RUN: begin
                if (first_len == 0 && second_len == 0) begin
                    held.union_value = '0;
                    held.last        = 1'b1;
                    held.empty_res   = 1'b1;
                    held.overflow    = dropped;
                end else begin
                    // Each distinct value is held back one step so that the
                    // final one can be marked before it is queued.
                    while (ia < first_len || ib < second_len) begin
                        if (ia < first_len &&
                            (ib >= second_len || first_vals[ia] <= second_vals[ib])) begin
                            pick = first_vals[ia];
                            ia++;
                        end else begin
                            pick = second_vals[ib];
                            ib++;
                        end
                        if (!have || pick != held.union_value) begin
                            if (have) queue_result(held);
                            held.union_value = pick;
                            held.last        = 1'b0;
                            held.empty_res   = 1'b0;
                            held.overflow    = dropped;
                            have             = 1'b1;
                        end
                    end
                    held.last = 1'b1;
                end
                queue_result(held);
                first_len  = 0;
                second_len = 0;
                dropped    = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_len  = 0;
            second_len = 0;
            dropped    = 1'b0;
            fail_total = 0;
            union_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (union_queue.size() == 0) begin
                    if (fail_total < REPORT_LIMIT)
                        $display("unexpected result: value %0d last %0b empty %0b ovf %0b",
                                 i_out_data.union_value, i_out_data.last,
                                 i_out_data.empty_res, i_out_data.overflow);
                    fail_total++;
                end else begin
                    if (i_out_data.union_value !== union_queue[0].union_value ||
                        i_out_data.last        !== union_queue[0].last ||
                        i_out_data.empty_res   !== union_queue[0].empty_res ||
                        i_out_data.overflow    !== union_queue[0].overflow) begin
                        // Fields are listed as value, last, empty, overflow.
                        if (fail_total < REPORT_LIMIT)
                            $display("mismatch: expected %0d,%0b,%0b,%0b got %0d,%0b,%0b,%0b",
                                     union_queue[0].union_value, union_queue[0].last,
                                     union_queue[0].empty_res, union_queue[0].overflow,
                                     i_out_data.union_value, i_out_data.last,
                                     i_out_data.empty_res, i_out_data.overflow);
                        fail_total++;
                    end
                    void'(union_queue.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) absorb_request(i_in_data);
        end
        o_fail_count = fail_total;
        o_pending    = union_queue.size();
    end

endmodule

// ===== dv/sorted_list_union_merge_test.sv =====
`timescale 1ns / 1ps

module sorted_list_union_merge_test;

    localparam int     LIST_DEPTH   = slum_pkg::LIST_DEPTH_DEF;
    localparam int     IDLE_LIMIT   = 5000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam longint INT_MAX      = 64'sd2147483647;
    localparam longint INT_MIN      = -64'sd2147483648;

    localparam logic [slum_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    slum_pkg::t_in  i_data;
    logic           o_stall;
    logic           o_valid;
    slum_pkg::t_out o_data;
    logic           i_stall;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int quiet_cycles;
    int stall_left;
    bit hold_req;

    sorted_list_union_merge #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    sorted_list_union_merge_checker #(.LIST_DEPTH(LIST_DEPTH)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: random stalls, or a long hold-off once one is requested.
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sorted_list_union_merge test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid stays high from one request to the next unless a gap is drawn.
    task automatic send_request(input logic [slum_pkg::FUNC_W-1:0] func,
                                input logic signed [slum_pkg::VALUE_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data.func  <= func;
        i_data.value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (func != FUNC_UNUSED) items_sent++;
    endtask

    // Two lists, usually ascending, appended in random interleaving, then a run.
    task automatic send_batch();
        longint next_val [2];
        int     left [2];
        int     side;
        bit     wide;
        bit     scrambled;
        logic signed [slum_pkg::VALUE_W-1:0] value;
        wide      = 1'($urandom_range(0, 1));
        scrambled = ($urandom_range(0, 6) == 0);
        for (int s = 0; s < 2; s++) begin
            if ($urandom_range(0, 7) == 0)
                left[s] = LIST_DEPTH + $urandom_range(0, 2);
            else
                left[s] = $urandom_range(0, 6);
            if (!wide)
                next_val[s] = longint'($urandom_range(0, 20)) - 10;
            else if ($urandom_range(0, 7) == 0)
                next_val[s] = INT_MIN;
            else
                next_val[s] = longint'($signed($urandom));
        end
        while (left[0] + left[1] > 0) begin
            if ($urandom_range(0, 19) == 0) send_request(FUNC_UNUSED, $urandom);
            if (left[0] > 0 && (left[1] == 0 || $urandom_range(0, 1) == 0))
                side = 0;
            else
                side = 1;
            if (scrambled)
                value = $urandom;
            else if (next_val[side] > INT_MAX)
                value = 32'(INT_MAX);
            else
                value = 32'(next_val[side]);
            next_val[side] += longint'(wide ? $urandom_range(0, 1 << 28) : $urandom_range(0, 3));
            send_request(side == 0 ? slum_pkg::FUNC_APPEND_FIRST
                                   : slum_pkg::FUNC_APPEND_SECOND, value);
            left[side]--;
        end
        send_request(slum_pkg::FUNC_RUN, $urandom);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 47;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Run with both lists empty.
        send_request(slum_pkg::FUNC_RUN, 32'sd0);
        // Extremes, ties across lists and a repeat within one list.
        send_request(slum_pkg::FUNC_APPEND_FIRST, 32'(INT_MIN));
        send_request(slum_pkg::FUNC_APPEND_FIRST, -32'sd1);
        send_request(slum_pkg::FUNC_APPEND_FIRST, 32'sd0);
        send_request(slum_pkg::FUNC_APPEND_FIRST, 32'(INT_MAX));
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'(INT_MIN));
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'sd0);
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'sd0);
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'sd7);
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'(INT_MAX));
        send_request(FUNC_UNUSED, -32'sd1);
        send_request(slum_pkg::FUNC_RUN, -32'sd1);
        // Out-of-order first list.
        send_request(slum_pkg::FUNC_APPEND_FIRST, 32'sd5);
        send_request(slum_pkg::FUNC_APPEND_FIRST, -32'sd3);
        send_request(slum_pkg::FUNC_APPEND_SECOND, 32'sd4);
        send_request(slum_pkg::FUNC_RUN, 32'sd0);
        // Only the second list holds data.
        send_request(slum_pkg::FUNC_APPEND_SECOND, -32'sd8);
        send_request(slum_pkg::FUNC_RUN, 32'sd0);

        while (items_sent < 155) send_batch();
        send_idle_pct = 47;
        recv_idle_pct = 11;
        while (items_sent < 290) send_batch();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        while (items_sent < 425) send_batch();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("sorted_list_union_merge test passed");
        end else begin
            $display("sorted_list_union_merge test failed");
        end
        $finish;
    end

endmodule
